@@ hdl/rles_pkg.sv @@
// ----------------------------------------------------------------------------
// rles_pkg
// Shared types, codes and helper functions for the RGB LED effect sequencer.
// ----------------------------------------------------------------------------
package rles_pkg;

  localparam int unsigned STEPS_PER_UNIT = 255;
  localparam int unsigned CHAN_N         = 3;

  localparam logic       REQ_SET  = 1'b0;
  localparam logic       REQ_TICK = 1'b1;

  localparam logic [1:0] EFF_NONE    = 2'd0;
  localparam logic [1:0] EFF_FADE    = 2'd1;
  localparam logic [1:0] EFF_PATTERN = 2'd2;
  localparam logic [1:0] EFF_WHEEL   = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_FADE  = 2'd1;
  localparam logic [1:0] MODE_WHEEL = 2'd2;
  localparam logic [1:0] MODE_FINAL = 2'd3;

  typedef logic [7:0] level_t;

  typedef struct packed {
    level_t r;
    level_t g;
    level_t b;
  } rgb_t;

  // exact x / 255 for x below 65280
  function automatic level_t div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return s[15:8];
  endfunction

  // color wheel at position k mod 255
  function automatic rgb_t wheel_color(input logic [15:0] k);
    logic [8:0] s1;
    logic [8:0] s2;
    level_t     p;
    level_t     q;
    level_t     q3;
    rgb_t       c;
    s1 = {1'b0, k[15:8]} + {1'b0, k[7:0]};
    s2 = {1'b0, s1[7:0]} + {8'd0, s1[8]};
    p  = (s2 >= 9'd255) ? 8'(s2 - 9'd255) : s2[7:0];
    c  = '0;
    if (p < 8'd85) begin
      q = p;
    end else if (p < 8'd170) begin
      q = p - 8'd85;
    end else begin
      q = p - 8'd170;
    end
    q3 = 8'({q, 1'b0} + {1'b0, q});
    if (p < 8'd85) begin
      c.r = 8'd255 - q3;
      c.b = q3;
    end else if (p < 8'd170) begin
      c.g = q3;
      c.b = 8'd255 - q3;
    end else begin
      c.r = q3;
      c.g = 8'd255 - q3;
    end
    return c;
  endfunction

endpackage

@@ hdl/rgb_led_effect_sequencer.sv @@
// ----------------------------------------------------------------------------
// rgb_led_effect_sequencer
// Set commands and animation ticks in, LED frames out; linear crossfade and
// color wheel runs built on one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// in_*      input      in_valid / in_ready    req_type, color, bright, on, effect, duration
// out_*     output     out_valid / out_ready  out_red/green/blue, out_final_frame
//
// Set command: multiply pass over three color channels, then it either emits
// a frame or starts a run.
// Fade tick: two multiplies and the serial divider (one quotient bit a cycle,
// 16 bits per color channel, three channels in turn).
// Wheel or final tick: computes one frame and emits it; a tick while idle emits nothing.
// A frame waits in the output register; the next transaction is accepted
// meanwhile and holds in the emit state only if the register is still full.
// Reset is synchronous, active low; no clearing pass.
// ----------------------------------------------------------------------------
module rgb_led_effect_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  rles_pkg::level_t     in_red,
  input  rles_pkg::level_t     in_green,
  input  rles_pkg::level_t     in_blue,
  input  rles_pkg::level_t     in_bright,
  input  logic                 in_on_flag,
  input  logic [1:0]           in_effect,
  input  logic [7:0]           in_duration,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rles_pkg::level_t     out_red,
  output rles_pkg::level_t     out_green,
  output rles_pkg::level_t     out_blue,
  output logic                 out_final_frame
);
  import rles_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SET_E    = 4'd1;
  localparam logic [3:0] S_SET_S    = 4'd2;
  localparam logic [3:0] S_SET_DONE = 4'd3;
  localparam logic [3:0] S_TICK     = 4'd4;
  localparam logic [3:0] S_FMUL_A   = 4'd5;
  localparam logic [3:0] S_FMUL_B   = 4'd6;
  localparam logic [3:0] S_FLOAD    = 4'd7;
  localparam logic [3:0] S_FDIV     = 4'd8;
  localparam logic [3:0] S_FSTORE   = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;

  localparam logic [1:0] CH_LAST = 2'(CHAN_N - 1);

  logic [3:0]  state_r;
  logic [1:0]  ch_r;

  level_t      nc_r [CHAN_N];
  level_t      nb_r;
  logic        non_r;
  logic [1:0]  eff_r;
  logic [7:0]  dur_r;

  level_t      cur_r [CHAN_N];
  level_t      cur_bright_r;
  logic        cur_on_r;
  logic [15:0] start_level_r [CHAN_N];
  logic [15:0] end_level_r [CHAN_N];
  level_t      final_level_r [CHAN_N];
  logic [15:0] step_count_r;
  logic [15:0] total_steps_r;
  logic [1:0]  mode_r;

  logic [15:0] tmi_r;
  logic [31:0] acc_r;
  logic [31:0] prod_r;
  logic [15:0] rem_r;
  logic [15:0] dvd_r;
  logic [15:0] q_r;
  logic [3:0]  cnt_r;

  level_t      frm_r [CHAN_N];
  logic        fin_r;

  logic        out_valid_r;
  level_t      out_red_r;
  level_t      out_green_r;
  level_t      out_blue_r;
  logic        out_fin_r;

  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] mul_p;
  logic [31:0] sum;
  logic [16:0] rem_sh;
  logic        ge;
  logic        keep_color;
  logic        emit_ok;
  rgb_t        whl;

  // shared multiplier
  always_comb begin
    case (state_r)
      S_SET_E: begin
        mul_a = {8'd0, nc_r[ch_r]};
        mul_b = {8'd0, nb_r};
      end
      S_SET_S: begin
        mul_a = {8'd0, cur_r[ch_r]};
        mul_b = {8'd0, cur_bright_r};
      end
      S_SET_DONE: begin
        mul_a = 16'(STEPS_PER_UNIT);
        mul_b = {8'd0, dur_r};
      end
      S_FMUL_A: begin
        mul_a = end_level_r[ch_r];
        mul_b = tmi_r;
      end
      S_FMUL_B: begin
        mul_a = start_level_r[ch_r];
        mul_b = step_count_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p      = mul_a * mul_b;
  assign sum        = acc_r + prod_r;
  assign rem_sh     = {rem_r, dvd_r[15]};
  assign ge         = rem_sh >= {1'b0, total_steps_r};
  assign keep_color = !non_r && nc_r[0] == 8'd0 && nc_r[1] == 8'd0 && nc_r[2] == 8'd0;
  assign emit_ok    = !out_valid_r || out_ready;
  assign whl        = wheel_color(step_count_r);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_final_frame = out_fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ch_r          <= '0;
      mode_r        <= MODE_IDLE;
      step_count_r  <= '0;
      total_steps_r <= '0;
      cur_bright_r  <= 8'd255;
      cur_on_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      cnt_r         <= '0;
      for (int c = 0; c < CHAN_N; c++) begin
        cur_r[c]         <= 8'd255;
        start_level_r[c] <= '0;
        end_level_r[c]   <= '0;
        final_level_r[c] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            nc_r[0]  <= in_red;
            nc_r[1]  <= in_green;
            nc_r[2]  <= in_blue;
            nb_r     <= (in_bright == 8'd0) ? 8'd255 : in_bright;
            non_r    <= (in_bright == 8'd0) ? 1'b0 : in_on_flag;
            eff_r    <= in_effect;
            dur_r    <= in_duration;
            ch_r     <= '0;
            state_r  <= (in_req_type == REQ_SET) ? S_SET_E : S_TICK;
          end
        end
        S_SET_E: begin
          end_level_r[ch_r] <= non_r ? mul_p[15:0] : 16'd0;
          state_r           <= S_SET_S;
        end
        S_SET_S: begin
          start_level_r[ch_r] <= cur_on_r ? mul_p[15:0] : 16'd0;
          final_level_r[ch_r] <= div255(end_level_r[ch_r]);
          if (ch_r == CH_LAST) begin
            state_r <= S_SET_DONE;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_SET_E;
          end
        end
        S_SET_DONE: begin
          total_steps_r <= mul_p[15:0];
          step_count_r  <= mul_p[15:0];
          if (!keep_color) begin
            for (int c = 0; c < CHAN_N; c++) begin
              cur_r[c] <= nc_r[c];
            end
          end
          cur_bright_r <= nb_r;
          cur_on_r     <= non_r;
          if (dur_r != 8'd0 && eff_r == EFF_FADE && mul_p[15:0] != 16'd0) begin
            mode_r  <= MODE_FADE;
            state_r <= S_IDLE;
          end else if (dur_r != 8'd0 && eff_r == EFF_WHEEL) begin
            mode_r  <= MODE_WHEEL;
            state_r <= S_IDLE;
          end else begin
            mode_r  <= MODE_IDLE;
            frm_r   <= final_level_r;
            fin_r   <= 1'b1;
            state_r <= S_EMIT;
          end
        end
        S_TICK: begin
          case (mode_r)
            MODE_FADE: begin
              if (total_steps_r == 16'd0 || step_count_r == 16'd0 ||
                  step_count_r > total_steps_r) begin
                mode_r  <= MODE_IDLE;
                frm_r   <= final_level_r;
                fin_r   <= 1'b1;
                state_r <= S_EMIT;
              end else begin
                tmi_r   <= total_steps_r - step_count_r;
                ch_r    <= '0;
                state_r <= S_FMUL_A;
              end
            end
            MODE_WHEEL: begin
              frm_r[0] <= whl.r;
              frm_r[1] <= whl.g;
              frm_r[2] <= whl.b;
              fin_r    <= 1'b0;
              if (step_count_r == 16'd0) begin
                mode_r <= MODE_FINAL;
              end else begin
                step_count_r <= step_count_r - 16'd1;
              end
              state_r <= S_EMIT;
            end
            MODE_FINAL: begin
              mode_r  <= MODE_IDLE;
              frm_r   <= final_level_r;
              fin_r   <= 1'b1;
              state_r <= S_EMIT;
            end
            default: begin
              state_r <= S_IDLE;
            end
          endcase
        end
        S_FMUL_A: begin
          acc_r   <= mul_p;
          state_r <= S_FMUL_B;
        end
        S_FMUL_B: begin
          prod_r  <= mul_p;
          state_r <= S_FLOAD;
        end
        S_FLOAD: begin
          rem_r   <= sum[31:16];
          dvd_r   <= sum[15:0];
          cnt_r   <= '0;
          state_r <= S_FDIV;
        end
        S_FDIV: begin
          rem_r <= ge ? 16'(rem_sh - {1'b0, total_steps_r}) : rem_sh[15:0];
          dvd_r <= {dvd_r[14:0], 1'b0};
          q_r   <= {q_r[14:0], ge};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= S_FSTORE;
          end
        end
        S_FSTORE: begin
          frm_r[ch_r] <= div255(q_r);
          if (ch_r == CH_LAST) begin
            fin_r        <= 1'b0;
            step_count_r <= step_count_r - 16'd1;
            if (step_count_r == 16'd1) begin
              mode_r <= MODE_FINAL;
            end
            state_r <= S_EMIT;
          end else begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_FMUL_A;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r <= 1'b1;
            out_red_r   <= frm_r[0];
            out_green_r <= frm_r[1];
            out_blue_r  <= frm_r[2];
            out_fin_r   <= fin_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE)
    else $error("accepted transaction did not start work");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FDIV |-> rem_r < total_steps_r)
    else $error("divider remainder not below divisor");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && mode_r == MODE_FADE |-> step_count_r <= total_steps_r)
    else $error("fade step count beyond run length");

  a_frame_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EMIT))
    else $error("frame loaded outside emit state");
`endif

endmodule
